/* hw/rtl/slbf_pkg.sv */
// Shared constants and types of the SYN/SYN/count byte framer.
package slbf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
  localparam logic [7:0] SYN_BYTE = 8'h16;

  // Status of the frame queue as seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
    logic wr_bank;
    logic rd_bank;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SYN1,
    BK_SYN2,
    BK_COUNT,
    BK_DATA_RD,
    BK_DATA_WAIT
  } back_state_t;

endpackage

/* hw/rtl/syn_length_byte_framer.sv */
// Top level of the SYN/SYN/byte-count framer.
//
// The input side is a queue: a payload beat (data_byte, end_of_message) is
// taken at a rising edge with push high and full low. One beat is taken per
// cycle while full stays low. The front part writes each beat into one bank
// of a two-bank payload RAM and closes the frame when the fill reaches the
// payload limit or when end_of_message is set; a closed frame enters a
// two-entry frame queue, so a new frame fills the other bank while the old
// one drains. full rises only when both banks hold frames not yet sent.
// The result side is a queue too: out_byte and frame_end are valid while
// empty is low and are taken at a rising edge with pop high. Each frame
// leaves as SYN, SYN, the count byte and then the payload, with frame_end
// on the final payload beat. Header beats leave one per cycle while pop is
// high; each payload beat passes the registered RAM read before it reaches
// the output register. A queued frame takes the back part out of BK_IDLE
// to load the SYNs. When the receiver holds pop low the output register keeps
// its beat, the back part waits, and input is stalled only once both banks
// are full. Reset (rst, synchronous) empties the frame queue and the output
// register, clears the fill and sets the limit to 32; cfg_we writes cfg_data.
module syn_length_byte_framer #(
  parameter int unsigned MAX_PAYLOAD = slbf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_message,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         frame_end,
  input  logic                         cfg_we,
  input  logic [slbf_pkg::LIMIT_W-1:0] cfg_data
);

  // Count width holds the full payload count; the RAM holds two banks.
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = $clog2(2 * MAX_PAYLOAD);

  slbf_pkg::q_status_t q_status;
  logic                q_push;
  logic [CW-1:0]       q_count;
  logic                q_pop;
  logic [CW-1:0]       head_count;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  slbf_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CW          (CW),
    .AW          (AW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .full           (full),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_count        (q_count),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  // Each queue entry owns the RAM bank named by its pointer.
  slbf_frame_queue #(
    .CW (CW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_count (q_count),
    .pop        (q_pop),
    .head_count (head_count),
    .status     (q_status)
  );

  slbf_ram #(
    .WIDTH (8),
    .DEPTH (2 * MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slbf_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CW          (CW),
    .AW          (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_count (head_count),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .frame_end  (frame_end)
  );

endmodule

/* hw/rtl/slbf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module slbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/slbf_frame_queue.sv */
// Two-entry queue of closed frames; each entry owns one bank of the payload RAM.
module slbf_frame_queue #(
  parameter int unsigned CW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [CW-1:0]       push_count,
  input  logic                pop,
  output logic [CW-1:0]       head_count,
  output slbf_pkg::q_status_t status
);

  logic [CW-1:0] count_q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      count_q[wr_ptr] <= push_count;
    end
  end

  assign head_count     = count_q[rd_ptr];
  assign status.full    = (level == 2'd2);
  assign status.empty   = (level == 2'd0);
  assign status.wr_bank = wr_ptr;
  assign status.rd_bank = rd_ptr;

endmodule

/* hw/rtl/slbf_front.sv */
// Front part: holds the limit register, stores payload beats and closes frames.
module slbf_front #(
  parameter int unsigned MAX_PAYLOAD = slbf_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned CW = $clog2(MAX_PAYLOAD + 1),
  parameter int unsigned AW = $clog2(2 * MAX_PAYLOAD)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_message,
  output logic                         full,
  input  logic                         cfg_we,
  input  logic [slbf_pkg::LIMIT_W-1:0] cfg_data,
  input  slbf_pkg::q_status_t          q_status,
  output logic                         q_push,
  output logic [CW-1:0]                q_count,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [7:0]                   ram_wdata
);

  localparam int unsigned LW = (CW > slbf_pkg::LIMIT_W) ? CW : slbf_pkg::LIMIT_W;

  logic [slbf_pkg::LIMIT_W-1:0] payload_limit;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                fill_next;
  logic [LW-1:0]                eff_limit;
  logic                         accept;
  logic                         close;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= slbf_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      payload_limit <= cfg_data;
    end
  end

  // A limit of zero behaves as one, a limit above the capacity as the capacity.
  always_comb begin
    eff_limit = LW'(payload_limit);
    if (eff_limit == '0) begin
      eff_limit = LW'(1);
    end
    if (eff_limit > LW'(MAX_PAYLOAD)) begin
      eff_limit = LW'(MAX_PAYLOAD);
    end
  end

  assign full      = q_status.full;
  assign accept    = push && !q_status.full;
  assign fill_next = fill + CW'(1);
  assign close     = accept && (end_of_message || (LW'(fill_next) >= eff_limit));

  assign ram_we    = accept;
  assign ram_wdata = data_byte;
  assign ram_waddr = q_status.wr_bank ? (AW'(MAX_PAYLOAD) + AW'(fill)) : AW'(fill);

  assign q_push  = close;
  assign q_count = fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (close) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

endmodule

/* hw/rtl/slbf_back.sv */
// Back part: sequences the header and payload beats of a frame into the output register.
module slbf_back #(
  parameter int unsigned MAX_PAYLOAD = slbf_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned CW = $clog2(MAX_PAYLOAD + 1),
  parameter int unsigned AW = $clog2(2 * MAX_PAYLOAD)
) (
  input  logic                clk,
  input  logic                rst,
  input  slbf_pkg::q_status_t q_status,
  input  logic [CW-1:0]       head_count,
  output logic                q_pop,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [7:0]          ram_rdata,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                frame_end
);

  slbf_pkg::back_state_t state;
  slbf_pkg::back_state_t state_next;

  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic          ovalid;
  logic          load;
  logic [7:0]    load_byte;
  logic          load_end;
  logic          free;
  logic          last_beat;

  assign free      = !ovalid || pop;
  assign last_beat = ((idx + CW'(1)) == head_count);
  assign ram_raddr = q_status.rd_bank ? (AW'(MAX_PAYLOAD) + AW'(idx)) : AW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slbf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    load_byte  = slbf_pkg::SYN_BYTE;
    load_end   = 1'b0;
    ram_re     = 1'b0;
    q_pop      = 1'b0;
    case (state)
      slbf_pkg::BK_IDLE: begin
        idx_next = '0;
        if (!q_status.empty) begin
          state_next = slbf_pkg::BK_SYN1;
        end
      end
      slbf_pkg::BK_SYN1: begin
        if (free) begin
          load       = 1'b1;
          state_next = slbf_pkg::BK_SYN2;
        end
      end
      slbf_pkg::BK_SYN2: begin
        if (free) begin
          load       = 1'b1;
          state_next = slbf_pkg::BK_COUNT;
        end
      end
      slbf_pkg::BK_COUNT: begin
        if (free) begin
          load       = 1'b1;
          load_byte  = 8'(head_count);
          state_next = slbf_pkg::BK_DATA_RD;
        end
      end
      slbf_pkg::BK_DATA_RD: begin
        ram_re     = 1'b1;
        state_next = slbf_pkg::BK_DATA_WAIT;
      end
      slbf_pkg::BK_DATA_WAIT: begin
        if (free) begin
          load      = 1'b1;
          load_byte = ram_rdata;
          load_end  = last_beat;
          if (last_beat) begin
            q_pop      = 1'b1;
            state_next = slbf_pkg::BK_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = slbf_pkg::BK_DATA_RD;
          end
        end
      end
      default: begin
        state_next = slbf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load) begin
      out_byte  <= load_byte;
      frame_end <= load_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  assign empty = !ovalid;

endmodule

/* tb/syn_length_byte_framer_chk.sv */
// Checker for the SYN/SYN/count framer: predicts every output beat and compares.
module slbf_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = slbf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_message,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [7:0]                   out_byte,
  input  logic                         frame_end,
  input  logic                         cfg_we,
  input  logic [slbf_pkg::LIMIT_W-1:0] cfg_data,
  output int unsigned                  mismatches,
  output int unsigned                  beats_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  frame_beat_t                  owed_q[$];
  logic [7:0]                   held_bytes[MAX_PAYLOAD];
  int unsigned                  held_count = 0;
  logic [slbf_pkg::LIMIT_W-1:0] limit_reg = slbf_pkg::LIMIT_RESET;
  int unsigned                  fail_count = 0;

  // A limit of zero behaves as one; anything above the store size is clipped.
  function automatic int unsigned closing_fill(input logic [slbf_pkg::LIMIT_W-1:0] lim);
    if (lim == '0) return 1;
    if (lim > MAX_PAYLOAD) return MAX_PAYLOAD;
    return 32'(lim);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Buffers one payload beat and, when the frame closes, queues the whole frame.
  task automatic absorb_beat(input logic [7:0] b, input logic eom);
    frame_beat_t beat;
    if (held_count < MAX_PAYLOAD) begin
      held_bytes[held_count] = b;
      held_count++;
    end
    if (eom || held_count >= closing_fill(limit_reg)) begin
      beat.value = slbf_pkg::SYN_BYTE;
      beat.last  = 1'b0;
      owed_q.push_back(beat);
      owed_q.push_back(beat);
      beat.value = 8'(held_count);
      owed_q.push_back(beat);
      for (int unsigned i = 0; i < held_count; i++) begin
        beat.value = held_bytes[i];
        beat.last  = (i + 1 == held_count);
        owed_q.push_back(beat);
      end
      held_count = 0;
    end
  endtask

  // A beat taken at the same edge as a limit write still sees the old limit.
  always @(posedge clk) begin
    if (rst) begin
      owed_q.delete();
      held_count = 0;
      limit_reg  = slbf_pkg::LIMIT_RESET;
    end else begin
      if (push && !full) absorb_beat(data_byte, end_of_message);
      if (cfg_we) limit_reg = cfg_data;
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("beat %02h/%0b with nothing owed", out_byte, frame_end));
        end else begin
          if (out_byte !== owed_q[0].value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte,
                                      owed_q[0].value));
          if (frame_end !== owed_q[0].last)
            report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h", frame_end,
                                      owed_q[0].last, owed_q[0].value));
          void'(owed_q.pop_front());
        end
      end
    end
    mismatches <= fail_count;
    beats_owed <= owed_q.size();
  end

endmodule

/* tb/syn_length_byte_framer_tb.sv */
// Top of the framer testbench: clock, reset, stimulus, receiver and verdict.
module syn_length_byte_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_W        = slbf_pkg::LIMIT_W;

  // Payload beats to offer over the whole run, directed part included.
  localparam int unsigned ITEMS          = 380;
  // Cycles allowed after the last owed beat before the block counts as idle.
  localparam int unsigned SETTLE_CYCLES  = 16;
  // Length of the one long receiver hold-off that forces the input to stall.
  localparam int unsigned LONG_HOLD      = 400;
  // Cycles with no beat moving on either side before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               push           = 1'b0;
  logic [7:0]         data_byte      = 8'h00;
  logic               end_of_message = 1'b0;
  logic               pop            = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [LIMIT_W-1:0] cfg_data       = '0;
  logic               full;
  logic               empty;
  logic [7:0]         out_byte;
  logic               frame_end;

  int unsigned mismatches;
  int unsigned beats_owed;

  // Sender bookkeeping: beats left in the current burst and beats taken so far.
  int unsigned burst_left = 0;
  int unsigned beats_sent = 0;

  // Receiver: the stimulus asks once for the long hold-off, the receiver
  // marks it as done so that it happens exactly once.
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned hold_left      = 0;
  logic [8:0]  rx_cycle       = '0;

  int unsigned idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  syn_length_byte_framer i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .frame_end      (frame_end),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  slbf_frame_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .frame_end      (frame_end),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .beats_owed     (beats_owed)
  );

  // Offers one payload beat and returns at the edge that takes it. The sender
  // works in bursts: when a burst runs out it may first idle with push low.
  // push is left high on return, so the caller must either offer the next
  // beat or lower push in the same time step.
  task automatic offer_beat(input logic [7:0] b, input logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push           <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (full);
    burst_left--;
    beats_sent++;
  endtask

  // A message of random bytes; the end flag goes on the last beat only when
  // the message is to be terminated, otherwise the fill is left pending.
  task automatic send_message(input int unsigned len, input logic terminate);
    for (int unsigned i = 0; i < len; i++)
      offer_beat(8'($urandom_range(0, 255)), terminate && (i + 1 == len));
  endtask

  // Waits until every owed beat has come out and the block has had time to
  // finish any write still in flight. push must already be low.
  task automatic wait_drained;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The limit is only changed while the block is quiet.
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    push <= 1'b0;
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    burst_left = 0;
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    int unsigned        n_msgs;
    int unsigned        len;
    logic               cut;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset limit of 32: the smallest and largest bytes framed
    // alone, then a two-byte message.
    offer_beat(8'h00, 1'b1);
    offer_beat(8'hFF, 1'b1);
    offer_beat(8'hA5, 1'b0);
    offer_beat(8'h5A, 1'b1);

    // A limit of zero must behave as one: each byte is a frame of its own.
    write_limit(6'd0);
    offer_beat(8'h12, 1'b0);
    offer_beat(8'h34, 1'b1);

    // Limit of three with five unterminated bytes: one full frame closes and
    // two bytes stay pending. Lowering the limit to one then closes a frame
    // of three on the very next byte, as the fill already passes the limit.
    write_limit(6'd3);
    send_message(5, 1'b0);
    write_limit(6'd1);
    offer_beat(8'h77, 1'b0);

    // Pressure: small frames while the receiver holds off for a long stretch,
    // so both banks fill and full has to rise. write_limit afterwards also
    // pauses the sender until everything owed has arrived.
    write_limit(6'd4);
    long_hold_req <= 1'b1;
    send_message(40, 1'b1);

    // A limit above the store size acts as the store size: a long message
    // must close a frame at exactly 32 bytes and carry the rest over.
    write_limit(6'd63);
    send_message($urandom_range(33, 45), 1'b1);

    // Random phases, each with a new limit and a handful of messages. Most
    // messages are short; some span several frames. The last message of a
    // phase is sometimes left open so the next limit lands mid-frame.
    while (beats_sent < ITEMS) begin
      case ($urandom_range(0, 7))
        0:       lim = 6'd0;
        1:       lim = 6'd1;
        2:       lim = 6'd32;
        3:       lim = 6'd63;
        4:       lim = LIMIT_W'($urandom_range(33, 62));
        default: lim = LIMIT_W'($urandom_range(2, 31));
      endcase
      write_limit(lim);
      n_msgs = $urandom_range(2, 6);
      for (int unsigned m = 0; m < n_msgs; m++) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(35, 70);
          1, 2:    len = $urandom_range(9, 34);
          default: len = $urandom_range(1, 8);
        endcase
        cut = (m + 1 == n_msgs) && ($urandom_range(0, 3) == 0);
        send_message(len, !cut);
      end
    end

    push <= 1'b0;
    wait_drained();
    if (mismatches == 0 && beats_owed == 0) begin
      $display("[syn_length_byte_framer] OK");
    end else begin
      $display("[syn_length_byte_framer] ERROR");
    end
    $finish;
  end

  // Receiver. Apart from the one long hold-off it cycles through four moods,
  // switched by rx_cycle[8:7]: always ready, coin flips, a fixed seven-in-eight
  // pattern and a heavy stall that takes about one beat in eight.
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      hold_left <= 0;
      rx_cycle  <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD;
        pop            <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0:    pop <= 1'b1;
          2'd1:    pop <= 1'($urandom_range(0, 1));
          2'd2:    pop <= (rx_cycle[2:0] != 3'd0);
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog: a run in which no beat moves for too long has hung.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[syn_length_byte_framer] ERROR");
      $finish;
    end
  end

endmodule
